// ===== rtl/cll_pkg.sv =====
`timescale 1ns / 1ps

package cll_pkg;

    localparam int CAPACITY_DEF    = 256;
    localparam int VALUE_WIDTH_DEF = 32;

    localparam int OP_W   = 4;
    localparam int DATA_W = 32;
    localparam int LEN_W  = 9;
    localparam int POS_W  = 9;
    localparam int ST_W   = 2;

    typedef enum logic [OP_W-1:0] {
        OP_CLEAR        = 4'd0,
        OP_PREPEND      = 4'd1,
        OP_APPEND       = 4'd2,
        OP_INS_BEFORE   = 4'd3,
        OP_INS_AFTER    = 4'd4,
        OP_DEL_FRONT    = 4'd5,
        OP_DEL_BACK     = 4'd6,
        OP_DEL_CURSOR   = 4'd7,
        OP_MOVE_FRONT   = 4'd8,
        OP_MOVE_BACK    = 4'd9,
        OP_MOVE_PREV    = 4'd10,
        OP_MOVE_NEXT    = 4'd11,
        OP_READ_FRONT   = 4'd12,
        OP_READ_BACK    = 4'd13,
        OP_READ_CURSOR  = 4'd14,
        OP_WRITE_CURSOR = 4'd15
    } t_op;

    typedef enum logic [ST_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_NOCUR = 2'd2,
        ST_FULL  = 2'd3
    } t_status;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load;      // capture the incoming transfer and its status
        logic rd;        // read the pool memories
        logic wr1;       // first write pass
        logic wr2;       // second write pass and register commit
        logic clr_wr;    // one free-chain entry of the clearing sweep
        logic clr_done;  // last sweep entry: reset list registers
        logic emit;      // load the result register
    } t_cmd;

    typedef struct packed {
        logic clr_last;
    } t_stat;

endpackage

// ===== rtl/cll_in_if.sv =====
`timescale 1ns / 1ps

interface cll_in_if import cll_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic [OP_W-1:0]          operation;
    logic signed [DATA_W-1:0] item_value;

    modport source (output valid, output operation, output item_value, input ready);
    modport sink   (input valid, input operation, input item_value, output ready);
endinterface

// ===== rtl/cll_out_if.sv =====
`timescale 1ns / 1ps

interface cll_out_if import cll_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] read_value;
    logic [LEN_W-1:0]         list_length;
    logic signed [POS_W-1:0]  cursor_position;
    logic [ST_W-1:0]          status;

    modport source (output valid, output read_value, output list_length,
                    output cursor_position, output status, input ready);
    modport sink   (input valid, input read_value, input list_length,
                    input cursor_position, input status, output ready);
endinterface

// ===== rtl/cursor_linked_list_engine_top.sv =====
`timescale 1ns / 1ps

// Channel   Role     Payload                                               Transfer
// i_in      sink     operation[3:0], item_value[31:0]                      valid & ready
// o_out     source   read_value, list_length, cursor_position, status      valid & ready
//
// One operation runs through accept, pool read, two write passes and result load.
// Clear rebuilds the free chain one pool entry per cycle
// through the single next-link write port.
// After reset the same sweep runs; no input is taken until it ends.
// A waiting result holds in the output register; the block holds in its final step
// until that register is free, and otherwise accepts while a result waits.
module cursor_linked_list_engine_top import cll_pkg::*; #(
    parameter int CAPACITY    = CAPACITY_DEF,
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    cll_in_if.sink    i_in,
    cll_out_if.source o_out
);

    t_cmd  w_cmd;
    t_stat w_stat;
    logic  w_in_clear;
    logic  w_in_ready;
    logic  w_out_valid;

    // decode clear early: it takes the sweep path instead of the read/write passes
    assign w_in_clear = (i_in.operation == OP_CLEAR);

    cll_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_in_clear  (w_in_clear),
        .o_in_ready  (w_in_ready),
        .i_out_ready (o_out.ready),
        .o_out_valid (w_out_valid),
        .o_cmd       (w_cmd),
        .i_stat      (w_stat)
    );

    cll_dpath #(
        .CAPACITY    (CAPACITY),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_dpath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (w_cmd),
        .o_stat            (w_stat),
        .i_op              (t_op'(i_in.operation)),
        .i_item_value      (i_in.item_value),
        .o_read_value      (o_out.read_value),
        .o_list_length     (o_out.list_length),
        .o_cursor_position (o_out.cursor_position),
        .o_status          (o_out.status)
    );

    assign i_in.ready  = w_in_ready;
    assign o_out.valid = w_out_valid;

`ifndef ASSERT_OFF
    // one operation at a time: after a transfer in, the block is busy
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in.valid && i_in.ready |=> !i_in.ready)
        else $error("input accepted while an operation is in progress");

    // an empty-list status leaves the list empty
    a_empty_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && (o_out.status == ST_EMPTY) |-> (o_out.list_length == '0))
        else $error("empty status with nonzero length");

    // an undefined-cursor status reports position minus one
    a_nocur_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && (o_out.status == ST_NOCUR) |-> (o_out.cursor_position == '1))
        else $error("cursor status with a defined position");

    // no result is loaded in the same cycle as a transfer in or a sweep write
    a_cmd_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.emit |-> !w_cmd.load && !w_cmd.clr_wr)
        else $error("result load overlaps accept or sweep");
`endif

endmodule

// ===== rtl/cll_ctrl.sv =====
`timescale 1ns / 1ps

module cll_ctrl import cll_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    input  logic  i_in_clear,
    output logic  o_in_ready,
    input  logic  i_out_ready,
    output logic  o_out_valid,
    output t_cmd  o_cmd,
    input  t_stat i_stat
);

    typedef enum logic [2:0] {
        S_CLR,
        S_IDLE,
        S_RD,
        S_WR1,
        S_WR2,
        S_FIN
    } t_state;

    t_state r_state, n_state;
    logic   r_from_op;
    logic   r_out_valid;

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_CLR: begin
                o_cmd.clr_wr = 1'b1;
                if (i_stat.clr_last) begin
                    o_cmd.clr_done = 1'b1;
                    n_state = r_from_op ? S_FIN : S_IDLE;
                end
            end
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state = i_in_clear ? S_CLR : S_RD;
                end
            end
            S_RD: begin
                o_cmd.rd = 1'b1;
                n_state = S_WR1;
            end
            S_WR1: begin
                o_cmd.wr1 = 1'b1;
                n_state = S_WR2;
            end
            S_WR2: begin
                o_cmd.wr2 = 1'b1;
                n_state = S_FIN;
            end
            S_FIN: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.emit = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLR;
            r_from_op   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_cmd.load) begin
                r_from_op <= i_in_clear;
            end
            if (o_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

// ===== rtl/cll_dpath.sv =====
`timescale 1ns / 1ps

module cll_dpath import cll_pkg::*; #(
    parameter int CAPACITY    = CAPACITY_DEF,
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_cmd                     i_cmd,
    output t_stat                    o_stat,
    input  t_op                      i_op,
    input  logic signed [DATA_W-1:0] i_item_value,
    output logic signed [DATA_W-1:0] o_read_value,
    output logic [LEN_W-1:0]         o_list_length,
    output logic signed [POS_W-1:0]  o_cursor_position,
    output logic [ST_W-1:0]          o_status
);

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int PW = $clog2(CAPACITY + 1);

    typedef logic [PW-1:0] t_ptr;
    localparam t_ptr NIL = PW'(CAPACITY);

    // pool memories
    t_ptr                   r_next_mem [CAPACITY];
    t_ptr                   r_prev_mem [CAPACITY];
    logic [VALUE_WIDTH-1:0] r_val_mem  [CAPACITY];

    // list registers
    t_ptr          r_free, r_front, r_back, r_cur;
    logic [AW-1:0] r_idx;
    t_ptr          r_count;
    logic [AW-1:0] r_clr_idx;

    // per-transfer registers
    t_op                    r_op;
    logic [VALUE_WIDTH-1:0] r_x;
    t_status                r_st;
    logic                   r_do;
    t_ptr                   r_nxa, r_nxb, r_pv;
    logic [VALUE_WIDTH-1:0] r_vrd;

    // result register
    logic signed [DATA_W-1:0] r_read_value;
    logic [LEN_W-1:0]         r_list_length;
    logic signed [POS_W-1:0]  r_cursor_position;
    t_status                  r_status;

    t_status       w_st;
    logic          w_do;
    logic          w_empty, w_nocur, w_full;
    logic          w_del_f, w_del_b, w_del_m;
    t_ptr          w_del_node;
    logic          nx_we, pv_we, vl_we;
    logic [AW-1:0] nx_wa, pv_wa, vl_wa;
    t_ptr          nx_wd, pv_wd;
    logic [63:0]   w_x64;
    logic [63:0]   w_vrd64;
    logic [DATA_W-1:0] w_rv;

    function automatic logic [AW-1:0] adr(input t_ptr p);
        return p[AW-1:0];
    endfunction

    assign w_empty = (r_count == '0);
    assign w_nocur = (r_cur == NIL);
    assign w_full  = (r_free == NIL);

    // status of the incoming operation against the current list
    always_comb begin
        w_st = ST_OK;
        unique case (i_op) inside
            OP_PREPEND, OP_APPEND:
                w_st = w_full ? ST_FULL : ST_OK;
            OP_INS_BEFORE, OP_INS_AFTER:
                w_st = w_empty ? ST_EMPTY : (w_nocur ? ST_NOCUR : (w_full ? ST_FULL : ST_OK));
            OP_DEL_FRONT, OP_DEL_BACK, OP_READ_FRONT, OP_READ_BACK:
                w_st = w_empty ? ST_EMPTY : ST_OK;
            OP_DEL_CURSOR, OP_READ_CURSOR, OP_WRITE_CURSOR:
                w_st = w_empty ? ST_EMPTY : (w_nocur ? ST_NOCUR : ST_OK);
            default:
                w_st = ST_OK;
        endcase
        w_do = (w_st == ST_OK)
            && !(((i_op == OP_MOVE_FRONT) || (i_op == OP_MOVE_BACK)) && w_empty)
            && !(((i_op == OP_MOVE_PREV) || (i_op == OP_MOVE_NEXT)) && w_nocur);
    end

    assign w_x64 = 64'(i_item_value);

    // delete flavors: front-like, back-like, middle of the list
    assign w_del_f = r_do && ((r_op == OP_DEL_FRONT)
                   || ((r_op == OP_DEL_CURSOR) && (r_cur == r_front)));
    assign w_del_b = r_do && ((r_op == OP_DEL_BACK)
                   || ((r_op == OP_DEL_CURSOR) && (r_cur != r_front) && (r_cur == r_back)));
    assign w_del_m = r_do && (r_op == OP_DEL_CURSOR)
                   && (r_cur != r_front) && (r_cur != r_back);
    assign w_del_node = w_del_f ? r_front : (w_del_b ? r_back : r_cur);

    // next-link write port
    always_comb begin
        nx_we = 1'b0;
        nx_wa = '0;
        nx_wd = '0;
        if (i_cmd.clr_wr) begin
            nx_we = 1'b1;
            nx_wa = r_clr_idx;
            nx_wd = PW'(r_clr_idx) + PW'(1);
        end else if (i_cmd.wr1 && r_do) begin
            case (r_op)
                OP_PREPEND:    begin nx_we = 1'b1; nx_wa = adr(r_free); nx_wd = r_front; end
                OP_APPEND:     begin nx_we = 1'b1; nx_wa = adr(r_free); nx_wd = NIL;     end
                OP_INS_BEFORE: begin nx_we = 1'b1; nx_wa = adr(r_free); nx_wd = r_cur;   end
                OP_INS_AFTER:  begin nx_we = 1'b1; nx_wa = adr(r_free); nx_wd = r_nxb;   end
                default: begin
                    if (w_del_f || w_del_b || w_del_m) begin
                        nx_we = 1'b1;
                        nx_wa = adr(w_del_node);
                        nx_wd = r_free;
                    end
                end
            endcase
        end else if (i_cmd.wr2 && r_do) begin
            case (r_op)
                OP_APPEND: begin
                    nx_we = (r_back != NIL); nx_wa = adr(r_back); nx_wd = r_free;
                end
                OP_INS_BEFORE: begin
                    nx_we = (r_pv != NIL); nx_wa = adr(r_pv); nx_wd = r_free;
                end
                OP_INS_AFTER: begin
                    nx_we = 1'b1; nx_wa = adr(r_cur); nx_wd = r_free;
                end
                default: begin
                    if (w_del_b) begin
                        nx_we = (r_pv != NIL); nx_wa = adr(r_pv); nx_wd = NIL;
                    end else if (w_del_m) begin
                        nx_we = 1'b1; nx_wa = adr(r_pv); nx_wd = r_nxb;
                    end
                end
            endcase
        end
    end

    // prev-link write port
    always_comb begin
        pv_we = 1'b0;
        pv_wa = '0;
        pv_wd = '0;
        if (i_cmd.wr1 && r_do) begin
            case (r_op)
                OP_PREPEND:    begin pv_we = 1'b1; pv_wa = adr(r_free); pv_wd = NIL;    end
                OP_APPEND:     begin pv_we = 1'b1; pv_wa = adr(r_free); pv_wd = r_back; end
                OP_INS_BEFORE: begin pv_we = 1'b1; pv_wa = adr(r_free); pv_wd = r_pv;   end
                OP_INS_AFTER:  begin pv_we = 1'b1; pv_wa = adr(r_free); pv_wd = r_cur;  end
                default: begin
                    if (w_del_f) begin
                        pv_we = (r_nxb != NIL); pv_wa = adr(r_nxb); pv_wd = NIL;
                    end else if (w_del_m) begin
                        pv_we = 1'b1; pv_wa = adr(r_nxb); pv_wd = r_pv;
                    end
                end
            endcase
        end else if (i_cmd.wr2 && r_do) begin
            case (r_op)
                OP_PREPEND: begin
                    pv_we = (r_front != NIL); pv_wa = adr(r_front); pv_wd = r_free;
                end
                OP_INS_BEFORE: begin
                    pv_we = 1'b1; pv_wa = adr(r_cur); pv_wd = r_free;
                end
                OP_INS_AFTER: begin
                    pv_we = (r_nxb != NIL); pv_wa = adr(r_nxb); pv_wd = r_free;
                end
                default: pv_we = 1'b0;
            endcase
        end
    end

    // value write port
    always_comb begin
        vl_we = 1'b0;
        vl_wa = '0;
        if (i_cmd.wr1 && r_do) begin
            case (r_op) inside
                OP_PREPEND, OP_APPEND, OP_INS_BEFORE, OP_INS_AFTER: begin
                    vl_we = 1'b1; vl_wa = adr(r_free);
                end
                OP_WRITE_CURSOR: begin
                    vl_we = 1'b1; vl_wa = adr(r_cur);
                end
                default: vl_we = 1'b0;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (nx_we) begin
            r_next_mem[nx_wa] <= nx_wd;
        end
        if (pv_we) begin
            r_prev_mem[pv_wa] <= pv_wd;
        end
        if (vl_we) begin
            r_val_mem[vl_wa] <= r_x;
        end
        if (i_cmd.rd) begin
            r_nxa <= r_next_mem[adr(r_free)];
            r_nxb <= r_next_mem[adr((r_op == OP_DEL_FRONT) ? r_front : r_cur)];
            r_pv  <= r_prev_mem[adr((r_op == OP_DEL_BACK) ? r_back : r_cur)];
            r_vrd <= r_val_mem[adr((r_op == OP_READ_FRONT) ? r_front
                                 : ((r_op == OP_READ_BACK) ? r_back : r_cur))];
        end
    end

    // sign-extend the stored value to the result width
    always_comb begin
        w_vrd64 = 64'(r_vrd);
        for (int i = 0; i < DATA_W; i++) begin
            w_rv[i] = (i < VALUE_WIDTH) ? w_vrd64[i] : w_vrd64[VALUE_WIDTH-1];
        end
    end

    // capture and result
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op <= i_op;
            r_x  <= w_x64[VALUE_WIDTH-1:0];
            r_st <= w_st;
            r_do <= w_do;
        end
        if (i_cmd.emit) begin
            r_read_value <= (((r_op == OP_READ_FRONT) || (r_op == OP_READ_BACK)
                            || (r_op == OP_READ_CURSOR)) && (r_st == ST_OK))
                            ? $signed(w_rv) : '0;
            r_list_length     <= LEN_W'(r_count);
            r_cursor_position <= (r_cur == NIL) ? '1 : $signed(POS_W'(r_idx));
            r_status          <= r_st;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_free    <= '0;
            r_front   <= NIL;
            r_back    <= NIL;
            r_cur     <= NIL;
            r_idx     <= '0;
            r_count   <= '0;
            r_clr_idx <= '0;
        end else begin
            if (i_cmd.clr_wr) begin
                r_clr_idx <= o_stat.clr_last ? '0 : r_clr_idx + AW'(1);
            end
            if (i_cmd.clr_done) begin
                r_free  <= '0;
                r_front <= NIL;
                r_back  <= NIL;
                r_cur   <= NIL;
                r_idx   <= '0;
                r_count <= '0;
            end else if (i_cmd.wr2 && r_do) begin
                case (r_op)
                    OP_PREPEND: begin
                        r_free  <= r_nxa;
                        r_front <= r_free;
                        if (r_front == NIL) begin
                            r_back <= r_free;
                        end
                        r_count <= r_count + PW'(1);
                        if (r_cur != NIL) begin
                            r_idx <= r_idx + AW'(1);
                        end
                    end
                    OP_APPEND: begin
                        r_free <= r_nxa;
                        r_back <= r_free;
                        if (r_back == NIL) begin
                            r_front <= r_free;
                        end
                        r_count <= r_count + PW'(1);
                    end
                    OP_INS_BEFORE: begin
                        r_free <= r_nxa;
                        if (r_pv == NIL) begin
                            r_front <= r_free;
                        end
                        r_count <= r_count + PW'(1);
                        r_idx   <= r_idx + AW'(1);
                    end
                    OP_INS_AFTER: begin
                        r_free <= r_nxa;
                        if (r_nxb == NIL) begin
                            r_back <= r_free;
                        end
                        r_count <= r_count + PW'(1);
                    end
                    OP_DEL_FRONT, OP_DEL_BACK, OP_DEL_CURSOR: begin
                        r_count <= r_count - PW'(1);
                        r_free  <= w_del_node;
                        if (w_del_f) begin
                            r_front <= r_nxb;
                            if (r_nxb == NIL) begin
                                r_back <= NIL;
                            end
                        end else if (w_del_b) begin
                            r_back <= r_pv;
                            if (r_pv == NIL) begin
                                r_front <= NIL;
                            end
                        end
                        // deleting at the cursor always leaves it undefined
                        if (r_op == OP_DEL_CURSOR) begin
                            r_cur <= NIL;
                        end else if (w_del_f) begin
                            if (r_cur != NIL) begin
                                if (r_idx == '0) begin
                                    r_cur <= NIL;
                                end else begin
                                    r_idx <= r_idx - AW'(1);
                                end
                            end
                        end else if (r_cur == r_back) begin
                            r_cur <= NIL;
                        end
                    end
                    OP_MOVE_FRONT: begin
                        r_cur <= r_front;
                        r_idx <= '0;
                    end
                    OP_MOVE_BACK: begin
                        r_cur <= r_back;
                        r_idx <= AW'(r_count - PW'(1));
                    end
                    OP_MOVE_PREV: begin
                        r_cur <= r_pv;
                        r_idx <= r_idx - AW'(1);
                    end
                    OP_MOVE_NEXT: begin
                        r_cur <= r_nxb;
                        r_idx <= r_idx + AW'(1);
                    end
                    default: r_cur <= r_cur;
                endcase
            end
        end
    end

    assign o_stat.clr_last   = (r_clr_idx == AW'(CAPACITY - 1));
    assign o_read_value      = r_read_value;
    assign o_list_length     = r_list_length;
    assign o_cursor_position = r_cursor_position;
    assign o_status          = r_status;

endmodule

// ===== tb/sv/cursor_linked_list_engine_top_tb.sv =====
`timescale 1ns / 1ps

module cursor_linked_list_engine_top_tb;
    import cll_pkg::*;

    localparam int CAP       = CAPACITY_DEF;
    localparam int NIL       = CAP;
    localparam int CYCLE_CAP = 1000000;

    typedef struct packed {
        logic signed [DATA_W-1:0] read_value;
        logic [LEN_W-1:0]         list_length;
        logic signed [POS_W-1:0]  cursor_position;
        logic [ST_W-1:0]          status;
    } t_result;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    cll_in_if  in_ch ();
    cll_out_if out_ch ();

    cursor_linked_list_engine_top u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch.sink),
        .o_out   (out_ch.source)
    );

    always #1 i_clk = ~i_clk;

    // Shadow list state
    logic [DATA_W-1:0] pool_val [CAP];
    int                pool_nxt [CAP];
    int                pool_prv [CAP];
    int                free_hd, front_nd, back_nd, count, cur_nd, cur_idx;

    t_result result_q[$];
    int      errors;
    int      cycles;
    bit      hold_off;      // long receiver hold-off requested
    int      hold_cycles;
    int      burst_left;

    initial begin
        in_ch.valid      = 1'b0;
        in_ch.operation  = '0;
        in_ch.item_value = '0;
        out_ch.ready     = 1'b0;
        errors           = 0;
        cycles           = 0;
        hold_off         = 1'b0;
        hold_cycles      = 0;
        burst_left       = 0;
    end

    function automatic void rebuild_pool();
        for (int i = 0; i < CAP; i++) begin
            pool_nxt[i] = i + 1;
            pool_prv[i] = NIL;
        end
        free_hd  = 0;
        front_nd = NIL;
        back_nd  = NIL;
        count    = 0;
        cur_nd   = NIL;
        cur_idx  = -1;
    endfunction

    function automatic int alloc_node(logic [DATA_W-1:0] v);
        int n;
        n = free_hd;
        free_hd = pool_nxt[n];
        pool_val[n] = v;
        return n;
    endfunction

    function automatic void release_node(int n);
        pool_nxt[n] = free_hd;
        pool_prv[n] = NIL;
        free_hd = n;
    endfunction

    function automatic void unlink_front();
        int n;
        n = front_nd;
        if (cur_idx == 0) begin
            cur_nd = NIL;
            cur_idx = -1;
        end else if (cur_idx > 0) begin
            cur_idx--;
        end
        front_nd = pool_nxt[n];
        if (front_nd == NIL) back_nd = NIL;
        else pool_prv[front_nd] = NIL;
        count--;
        release_node(n);
    endfunction

    function automatic void unlink_back();
        int n;
        n = back_nd;
        if (cur_nd == n) begin
            cur_nd = NIL;
            cur_idx = -1;
        end
        back_nd = pool_prv[n];
        if (back_nd == NIL) front_nd = NIL;
        else pool_nxt[back_nd] = NIL;
        count--;
        release_node(n);
    endfunction

    // Apply one operation to the shadow list and return the result it yields
    function automatic t_result apply_list_op(t_op op, logic [DATA_W-1:0] v);
        t_result r;
        bit      is_empty, no_cur, is_full;
        int      n, nb;
        r = '0;
        r.status = ST_OK;
        is_empty = (count == 0);
        no_cur   = (cur_nd == NIL);
        is_full  = (free_hd == NIL);
        case (op)
            OP_CLEAR: rebuild_pool();
            OP_PREPEND: begin
                if (is_full) r.status = ST_FULL;
                else begin
                    n = alloc_node(v);
                    pool_nxt[n] = front_nd;
                    pool_prv[n] = NIL;
                    if (front_nd == NIL) back_nd = n;
                    else pool_prv[front_nd] = n;
                    front_nd = n;
                    count++;
                    if (!no_cur) cur_idx++;
                end
            end
            OP_APPEND: begin
                if (is_full) r.status = ST_FULL;
                else begin
                    n = alloc_node(v);
                    pool_prv[n] = back_nd;
                    pool_nxt[n] = NIL;
                    if (back_nd == NIL) front_nd = n;
                    else pool_nxt[back_nd] = n;
                    back_nd = n;
                    count++;
                end
            end
            OP_INS_BEFORE, OP_INS_AFTER: begin
                if (is_empty) r.status = ST_EMPTY;
                else if (no_cur) r.status = ST_NOCUR;
                else if (is_full) r.status = ST_FULL;
                else begin
                    n = alloc_node(v);
                    if (op == OP_INS_BEFORE) begin
                        nb = pool_prv[cur_nd];
                        pool_prv[n] = nb;
                        pool_nxt[n] = cur_nd;
                        pool_prv[cur_nd] = n;
                        if (nb == NIL) front_nd = n;
                        else pool_nxt[nb] = n;
                        cur_idx++;
                    end else begin
                        nb = pool_nxt[cur_nd];
                        pool_nxt[n] = nb;
                        pool_prv[n] = cur_nd;
                        pool_nxt[cur_nd] = n;
                        if (nb == NIL) back_nd = n;
                        else pool_prv[nb] = n;
                    end
                    count++;
                end
            end
            OP_DEL_FRONT: if (is_empty) r.status = ST_EMPTY; else unlink_front();
            OP_DEL_BACK:  if (is_empty) r.status = ST_EMPTY; else unlink_back();
            OP_DEL_CURSOR: begin
                if (is_empty) r.status = ST_EMPTY;
                else if (no_cur) r.status = ST_NOCUR;
                else begin
                    n = cur_nd;
                    if (n == front_nd) unlink_front();
                    else if (n == back_nd) unlink_back();
                    else begin
                        pool_nxt[pool_prv[n]] = pool_nxt[n];
                        pool_prv[pool_nxt[n]] = pool_prv[n];
                        count--;
                        release_node(n);
                    end
                    cur_nd = NIL;
                    cur_idx = -1;
                end
            end
            OP_MOVE_FRONT: if (!is_empty) begin
                cur_nd = front_nd;
                cur_idx = 0;
            end
            OP_MOVE_BACK: if (!is_empty) begin
                cur_nd = back_nd;
                cur_idx = count - 1;
            end
            OP_MOVE_PREV, OP_MOVE_NEXT: if (!no_cur) begin
                cur_nd = (op == OP_MOVE_PREV) ? pool_prv[cur_nd] : pool_nxt[cur_nd];
                if (cur_nd == NIL) cur_idx = -1;
                else if (op == OP_MOVE_PREV) cur_idx--;
                else cur_idx++;
            end
            OP_READ_FRONT: if (is_empty) r.status = ST_EMPTY;
                           else r.read_value = pool_val[front_nd];
            OP_READ_BACK:  if (is_empty) r.status = ST_EMPTY;
                           else r.read_value = pool_val[back_nd];
            OP_READ_CURSOR: begin
                if (is_empty) r.status = ST_EMPTY;
                else if (no_cur) r.status = ST_NOCUR;
                else r.read_value = pool_val[cur_nd];
            end
            default: begin
                if (is_empty) r.status = ST_EMPTY;
                else if (no_cur) r.status = ST_NOCUR;
                else pool_val[cur_nd] = v;
            end
        endcase
        r.list_length     = count[LEN_W-1:0];
        r.cursor_position = cur_idx[POS_W-1:0];
        return r;
    endfunction

    // Offer one operation, hold it until the transfer, then predict its result
    task automatic send_op(t_op op, logic [DATA_W-1:0] v);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            gap = ($urandom_range(0, 3) == 0) ? 1 : $urandom_range(1, 6);
            repeat (gap) @(negedge i_clk);
        end
        in_ch.valid      <= 1'b1;
        in_ch.operation  <= op;
        in_ch.item_value <= v;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        result_q.push_back(apply_list_op(op, v));
        @(negedge i_clk);
        burst_left--;
        // drop valid only at the end of a burst
        if (burst_left == 0) in_ch.valid <= 1'b0;
    endtask

    function automatic logic [DATA_W-1:0] edge_value();
        case ($urandom_range(0, 5))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'hFFFF_FFFF;
            3: return 32'h0;
            default: return $urandom();
        endcase
    endfunction

    // Receiver: random stall pattern, plus a long hold-off on request
    always @(negedge i_clk) begin
        if (hold_off) begin
            out_ch.ready <= 1'b0;
            hold_cycles++;
            if (hold_cycles >= 200) hold_off <= 1'b0;
        end else begin
            out_ch.ready <= (cycles % 500 < 150) ? 1'b1 : ($urandom_range(0, 3) != 0);
        end
    end

    // Compare every result transfer with the oldest prediction
    always @(posedge i_clk) begin
        t_result exp_r;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (result_q.size() == 0) begin
                $display("%0t: unexpected result rv=%0d len=%0d pos=%0d st=%0d", $time,
                         out_ch.read_value, out_ch.list_length, out_ch.cursor_position,
                         out_ch.status);
                errors++;
            end else begin
                exp_r = result_q.pop_front();
                if (out_ch.read_value !== exp_r.read_value) begin
                    $display("%0t: read_value expected %0d actual %0d", $time,
                             exp_r.read_value, out_ch.read_value);
                    errors++;
                end
                if (out_ch.list_length !== exp_r.list_length) begin
                    $display("%0t: list_length expected %0d actual %0d", $time,
                             exp_r.list_length, out_ch.list_length);
                    errors++;
                end
                if (out_ch.cursor_position !== exp_r.cursor_position) begin
                    $display("%0t: cursor_position expected %0d actual %0d", $time,
                             exp_r.cursor_position, out_ch.cursor_position);
                    errors++;
                end
                if (out_ch.status !== exp_r.status) begin
                    $display("%0t: status expected %0d actual %0d", $time,
                             exp_r.status, out_ch.status);
                    errors++;
                end
            end
        end
    end

    // Watchdog: end the run if it hangs
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_CAP) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Directed: every operation in turn, starting from an empty list, then edges and cursor cases
    task automatic test_directed();
        for (int op = 0; op < 16; op++) send_op(t_op'(op), edge_value());
        send_op(OP_APPEND, 32'h8000_0000);
        send_op(OP_PREPEND, 32'h7FFF_FFFF);
        send_op(OP_INS_BEFORE, 32'h1);     // cursor undefined
        send_op(OP_READ_CURSOR, 32'h0);
        send_op(OP_MOVE_FRONT, 32'h0);
        send_op(OP_INS_BEFORE, 32'hFFFF_FFFF);
        send_op(OP_INS_AFTER, 32'h5);
        send_op(OP_MOVE_PREV, 32'h0);
        send_op(OP_MOVE_PREV, 32'h0);      // walk off the front
        send_op(OP_MOVE_BACK, 32'h0);
        send_op(OP_WRITE_CURSOR, 32'hDEAD_BEEF);
        send_op(OP_READ_BACK, 32'h0);
        send_op(OP_MOVE_NEXT, 32'h0);      // walk off the back
        send_op(OP_DEL_FRONT, 32'h0);
        send_op(OP_MOVE_BACK, 32'h0);
        send_op(OP_DEL_CURSOR, 32'h0);
        send_op(OP_READ_FRONT, 32'h0);
    endtask

    // Fill the pool to capacity, hit the full case, then clear
    task automatic test_pool_full();
        while (count < CAP) send_op(OP_APPEND, $urandom());
        send_op(OP_PREPEND, 32'h1);
        send_op(OP_MOVE_FRONT, 32'h0);
        send_op(OP_INS_AFTER, 32'h2);
        send_op(OP_MOVE_BACK, 32'h0);
        send_op(OP_READ_CURSOR, 32'h0);
        send_op(OP_CLEAR, 32'h0);
    endtask

    // Stop the receiver for a long stretch while operations keep arriving
    task automatic test_backpressure();
        hold_cycles = 0;
        hold_off = 1'b1;
        repeat (40) send_op(($urandom_range(0, 1) != 0) ? OP_APPEND : OP_READ_BACK,
                            $urandom());
    endtask

    // Random mix weighted toward inserts and cursor traffic, rare clears
    task automatic test_random(int n_items);
        int pick;
        t_op op;
        for (int i = 0; i < n_items; i++) begin
            pick = $urandom_range(0, 99);
            if (pick == 0) op = OP_CLEAR;
            else if (pick < 30) op = t_op'($urandom_range(1, 4));
            else if (pick < 45) op = t_op'($urandom_range(5, 7));
            else if (pick < 70) op = t_op'($urandom_range(8, 11));
            else op = t_op'($urandom_range(12, 15));
            send_op(op, edge_value());
        end
    endtask

    initial begin
        rebuild_pool();
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        test_backpressure();
        test_pool_full();
        test_random(390);
        // close an unfinished burst
        if (burst_left != 0) begin
            burst_left = 0;
            in_ch.valid <= 1'b0;
        end
        while (result_q.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (errors == 0) $display("Testbench completed without errors");
        else $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/cll_pkg.sv
rtl/cll_in_if.sv
rtl/cll_out_if.sv
rtl/cll_ctrl.sv
rtl/cll_dpath.sv
rtl/cursor_linked_list_engine_top.sv
tb/sv/cursor_linked_list_engine_top_tb.sv
